FILE: src/dnos_pkg.sv
// dnos_pkg: shared opcodes, command and slot types, state enum for the
// delayed note-off scheduler. no dependencies.
`timescale 1ns / 1ps

package dnos_pkg;

   localparam int DNOS_SLOT_COUNT  = 32;
   localparam int DNOS_QUEUE_DEPTH = 2;

   localparam logic [2:0] OP_INSERT         = 3'd0;
   localparam logic [2:0] OP_PLAY_DUE       = 3'd1;
   localparam logic [2:0] OP_OFF_IF_PRESENT = 3'd2;
   localparam logic [2:0] OP_OFF_NOW        = 3'd3;
   localparam logic [2:0] OP_ALL_OFF        = 3'd4;

   localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

   localparam logic KIND_NOTE_OFF = 1'b0;
   localparam logic KIND_STATUS   = 1'b1;

   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_PLAY,
      CMD_OFF,
      CMD_NONE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         always_emit;
      logic [6:0]   note;
      logic [4:0]   channel;
      logic [31:0]  time_value;
      logic         send_cv;
   } cmd_type;

   typedef struct packed {
      logic [6:0]  note;
      logic [4:0]  channel;
      logic [31:0] due;
      logic        cv;
   } slot_entry_type;

   typedef struct packed {
      logic       kind;
      logic [6:0] off_note;
      logic [4:0] off_channel;
      logic       cv_off;
      logic       success;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_EXTRA,
      BK_STATUS
   } back_state_type;

endpackage

FILE: src/dnos_req_if.sv
// dnos_req_if: request channel, valid/ready plus one operation.
// no dependencies.
`timescale 1ns / 1ps

interface dnos_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [6:0]  note;
   logic [4:0]  channel;
   logic [31:0] time_value;
   logic        send_cv;

   modport source (output valid, output opcode, output note, output channel,
                   output time_value, output send_cv, input ready);
   modport sink (input valid, input opcode, input note, input channel,
                 input time_value, input send_cv, output ready);
endinterface

FILE: src/dnos_rsp_if.sv
// dnos_rsp_if: response channel, valid/ready plus one note-off or status item.
// no dependencies.
`timescale 1ns / 1ps

interface dnos_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [6:0] off_note;
   logic [4:0] off_channel;
   logic       cv_off;
   logic       success;
   logic       last;

   modport source (output valid, output kind, output off_note, output off_channel,
                   output cv_off, output success, output last, input ready);
   modport sink (input valid, input kind, input off_note, input off_channel,
                 input cv_off, input success, input last, output ready);
endinterface

FILE: src/dnos_cmd_queue.sv
// dnos_cmd_queue: short command queue between front and back.
// depends on dnos_pkg.
`timescale 1ns / 1ps

module dnos_cmd_queue import dnos_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_data,
   input  logic             pop,
   output cmd_type          pop_data,
   output queue_status_type status
);

   localparam int PTR_W = (DNOS_QUEUE_DEPTH > 1) ? $clog2(DNOS_QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(DNOS_QUEUE_DEPTH + 1);

   cmd_type          store_ff [DNOS_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DNOS_QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DNOS_QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   assign pop_data     = store_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DNOS_QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/dnos_front.sv
// dnos_front: accepts requests and classifies each opcode into a command.
// depends on dnos_pkg and dnos_req_if.
`timescale 1ns / 1ps

module dnos_front import dnos_pkg::*; (
   dnos_req_if.sink         req_port,
   input  queue_status_type queue_status,
   output logic             push,
   output cmd_type          push_data
);

   assign req_port.ready = !queue_status.full;
   assign push           = req_port.valid && !queue_status.full;

   always_comb begin
      push_data.always_emit = 1'b0;
      push_data.note        = req_port.note;
      push_data.channel     = req_port.channel;
      push_data.time_value  = req_port.time_value;
      push_data.send_cv     = req_port.send_cv;
      unique case (req_port.opcode)
         OP_INSERT:         push_data.kind = CMD_INSERT;
         OP_PLAY_DUE:       push_data.kind = CMD_PLAY;
         OP_OFF_IF_PRESENT: push_data.kind = CMD_OFF;
         OP_OFF_NOW: begin
            push_data.kind        = CMD_OFF;
            push_data.always_emit = 1'b1;
         end
         OP_ALL_OFF: begin
            push_data.kind       = CMD_PLAY;
            push_data.time_value = TIME_MAX;
         end
         default:           push_data.kind = CMD_NONE;
      endcase
   end

endmodule

FILE: src/dnos_back.sv
// dnos_back: slot table and scanner, one slot per cycle when not stalled, with output register.
// depends on dnos_pkg and dnos_rsp_if.
`timescale 1ns / 1ps

module dnos_back import dnos_pkg::*; #(
   parameter int SLOT_COUNT = DNOS_SLOT_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd_data,
   input  queue_status_type queue_status,
   output logic             pop,
   dnos_rsp_if.source       rsp_port
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   slot_entry_type  slot_mem [SLOT_COUNT];
   slot_entry_type  rd_entry_ff;
   logic [SLOT_COUNT-1:0] slot_valid_ff, slot_valid_in;

   back_state_type  state_ff, state_in;
   cmd_type         cmd_ff;
   logic [CNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic            cmp_valid_ff, cmp_valid_in;
   logic            found_ff, found_in;
   logic            out_valid_ff, out_valid_in;
   rsp_item_type    out_item_ff, out_item_in;

   logic out_free;
   logic issue_more;
   logic slot_v;
   logic cmp_hit;
   logic emit_need;
   logic cmp_done;
   logic insert_stop;
   logic issue_go;
   logic scan_end;
   logic cmd_load;
   logic mem_wr;
   logic out_load;

   // scan datapath and strobes
   always_comb begin
      out_free   = !out_valid_ff || rsp_port.ready;
      issue_more = (issue_cnt_ff != CNT_W'(SLOT_COUNT));
      slot_v     = slot_valid_ff[cmp_idx_ff];
      unique case (cmd_ff.kind)
         CMD_INSERT: cmp_hit = !slot_v;
         CMD_PLAY:   cmp_hit = slot_v && (rd_entry_ff.due <= cmd_ff.time_value);
         CMD_OFF:    cmp_hit = slot_v && (rd_entry_ff.note == cmd_ff.note)
                               && (rd_entry_ff.channel == cmd_ff.channel);
         CMD_NONE:   cmp_hit = 1'b0;
      endcase
      emit_need   = cmp_hit && ((cmd_ff.kind == CMD_PLAY)
                                || ((cmd_ff.kind == CMD_OFF) && !found_ff));
      cmp_done    = (state_ff == BK_SCAN) && cmp_valid_ff && (!emit_need || out_free);
      insert_stop = cmp_done && cmp_hit && (cmd_ff.kind == CMD_INSERT);
      issue_go    = (state_ff == BK_SCAN) && issue_more && !insert_stop
                    && (!cmp_valid_ff || cmp_done);
      scan_end    = (state_ff == BK_SCAN)
                    && (insert_stop || (!issue_more && (!cmp_valid_ff || cmp_done)));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_status.empty) begin
               state_in = (cmd_data.kind == CMD_NONE) ? BK_STATUS : BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (scan_end) begin
               state_in = ((cmd_ff.kind == CMD_OFF) && cmd_ff.always_emit && !found_in)
                          ? BK_EXTRA : BK_STATUS;
            end
         end
         BK_EXTRA: begin
            if (out_free) begin
               state_in = BK_STATUS;
            end
         end
         BK_STATUS: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
      endcase
   end

   // state outputs
   always_comb begin
      pop           = 1'b0;
      cmd_load      = 1'b0;
      mem_wr        = 1'b0;
      out_load      = 1'b0;
      found_in      = found_ff;
      slot_valid_in = slot_valid_ff;
      cmp_valid_in  = cmp_valid_ff;
      issue_cnt_in  = issue_cnt_ff;
      out_item_in   = out_item_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_status.empty) begin
               pop          = 1'b1;
               cmd_load     = 1'b1;
               found_in     = 1'b0;
               issue_cnt_in = '0;
               cmp_valid_in = 1'b0;
            end
         end
         BK_SCAN: begin
            if (cmp_done) begin
               cmp_valid_in = 1'b0;
               if (cmp_hit) begin
                  found_in = 1'b1;
                  if (cmd_ff.kind == CMD_INSERT) begin
                     slot_valid_in[cmp_idx_ff] = 1'b1;
                     mem_wr                    = 1'b1;
                  end else begin
                     slot_valid_in[cmp_idx_ff] = 1'b0;
                  end
               end
               if (emit_need) begin
                  out_load                = 1'b1;
                  out_item_in.kind        = KIND_NOTE_OFF;
                  out_item_in.off_note    = rd_entry_ff.note;
                  out_item_in.off_channel = rd_entry_ff.channel;
                  out_item_in.cv_off      = rd_entry_ff.cv;
                  out_item_in.success     = 1'b0;
                  out_item_in.last        = 1'b0;
               end
            end
            if (issue_go) begin
               cmp_valid_in = 1'b1;
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
            end
         end
         BK_EXTRA: begin
            if (out_free) begin
               out_load                = 1'b1;
               out_item_in.kind        = KIND_NOTE_OFF;
               out_item_in.off_note    = cmd_ff.note;
               out_item_in.off_channel = cmd_ff.channel;
               out_item_in.cv_off      = cmd_ff.send_cv;
               out_item_in.success     = 1'b0;
               out_item_in.last        = 1'b0;
            end
         end
         BK_STATUS: begin
            if (out_free) begin
               out_load                = 1'b1;
               out_item_in.kind        = KIND_STATUS;
               out_item_in.off_note    = '0;
               out_item_in.off_channel = '0;
               out_item_in.cv_off      = 1'b0;
               out_item_in.success     = found_ff;
               out_item_in.last        = 1'b1;
            end
         end
      endcase
      out_valid_in = out_load || (out_valid_ff && !rsp_port.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         slot_valid_ff <= '0;
         cmp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
         issue_cnt_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         cmp_valid_ff  <= cmp_valid_in;
         found_ff      <= found_in;
         issue_cnt_ff  <= issue_cnt_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload and slot memory
   always_ff @(posedge clock) begin
      if (cmd_load) begin
         cmd_ff <= cmd_data;
      end
      if (out_load) begin
         out_item_ff <= out_item_in;
      end
      if (issue_go) begin
         rd_entry_ff <= slot_mem[issue_cnt_ff[IDX_W-1:0]];
         cmp_idx_ff  <= issue_cnt_ff[IDX_W-1:0];
      end
      if (mem_wr) begin
         slot_mem[cmp_idx_ff] <= '{note: cmd_ff.note, channel: cmd_ff.channel,
                                   due: cmd_ff.time_value, cv: cmd_ff.send_cv};
      end
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.kind        = out_item_ff.kind;
   assign rsp_port.off_note    = out_item_ff.off_note;
   assign rsp_port.off_channel = out_item_ff.off_channel;
   assign rsp_port.cv_off      = out_item_ff.cv_off;
   assign rsp_port.success     = out_item_ff.success;
   assign rsp_port.last        = out_item_ff.last;

endmodule

FILE: src/delayed_note_off_scheduler_core.sv
// delayed_note_off_scheduler_core: top level, front decode, command queue, back scanner.
// depends on dnos_pkg, dnos_req_if, dnos_rsp_if, dnos_front, dnos_cmd_queue, dnos_back.
//
//   channel   modport  direction  carries
//   req_port  sink     in         opcode, note, channel, time_value, send_cv
//   rsp_port  source   out        kind, off_note, off_channel, cv_off, success, last
//
// an operation in the back loads the command, reads one slot per cycle through the slot
// memory read port unless the output stalls, compares each, and ends with a status item;
// insert stops at the first free slot; an unused opcode skips the scan, sending only status
// off now with no match sends its own note-off before the status item
// reset is synchronous and clears valid bits, queue and state; slot contents stay unknown
// a stalled response holds the scanner's compare stage; the queue takes requests until full
`timescale 1ns / 1ps

module delayed_note_off_scheduler_core import dnos_pkg::*; #(
   parameter int SLOT_COUNT = DNOS_SLOT_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   dnos_req_if.sink    req_port,
   dnos_rsp_if.source  rsp_port
);

   queue_status_type queue_status;
   logic             push;
   cmd_type          push_data;
   logic             pop;
   cmd_type          pop_data;

   dnos_front u_front (
      .req_port     (req_port),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   dnos_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   dnos_back #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_data     (pop_data),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_port     (rsp_port)
   );

endmodule
